// ----- hw/rtl/nrco_pkg.sv -----
// Shared types, widths and constants for the NTP reply clock offset block.
package nrco_pkg;

	// Field widths
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned MS_W    = 10;
	localparam int unsigned LIMIT_W = 16;
	localparam int unsigned QUOT_W  = 23;
	localparam int unsigned FPROD_W = TIME_W + MS_W;

	// Conversion constants
	localparam logic [TIME_W-1:0]  NTP_UNIX_OFFSET = 32'd2208988800;
	localparam logic [MS_W-1:0]    MS_PER_S        = 10'd1000;
	localparam logic [MS_W-1:0]    MS_MAX          = 10'd999;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 16'd100;

	// Reciprocal of 1000 for a 32-bit dividend: q = (n * DIV1000_MAGIC) >> DIV1000_SHIFT
	localparam logic [TIME_W-1:0]  DIV1000_MAGIC   = 32'h10624DD3;
	localparam int unsigned        DIV1000_SHIFT   = 38;

	// Event kinds carried in the action field
	typedef enum logic {
		ACT_REQUEST = 1'b0,
		ACT_REPLY   = 1'b1
	} action_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_REQUEST_RECORDED = 2'd0,
		ST_REPLY_IGNORED    = 2'd1,
		ST_REPLY_TOO_SLOW   = 2'd2,
		ST_TIME_UPDATED     = 2'd3
	} status_t;

	// Operands for the epoch base calculation
	typedef struct packed {
		logic [TIME_W-1:0] unix_sec;
		logic [QUOT_W-1:0] quot;
		logic [MS_W-1:0]   now_lo;
		logic [MS_W-1:0]   frac_ms;
	} conv_in_t;

	// Epoch base produced by the calculation
	typedef struct packed {
		logic [TIME_W-1:0] seconds;
		logic [MS_W-1:0]   millis;
	} conv_out_t;

endpackage

// ----- hw/rtl/nrco_if.sv -----
// Handshake channels for events into and results out of the offset block.
interface nrco_event_if;
	import nrco_pkg::*;

	logic              valid;
	logic              ready;
	action_t           action;
	logic [TIME_W-1:0] now_ms;
	logic [TIME_W-1:0] ntp_seconds;
	logic [TIME_W-1:0] ntp_fraction;

	modport source (output valid, action, now_ms, ntp_seconds, ntp_fraction, input ready);
	modport sink (input valid, action, now_ms, ntp_seconds, ntp_fraction, output ready);
endinterface

interface nrco_result_if;
	import nrco_pkg::*;

	logic              valid;
	logic              ready;
	status_t           status;
	logic [TIME_W-1:0] round_trip_ms;
	logic [TIME_W-1:0] epoch_seconds;
	logic [MS_W-1:0]   epoch_millis;
	logic              time_known;

	modport source (output valid, status, round_trip_ms, epoch_seconds, epoch_millis, time_known,
		input ready);
	modport sink (input valid, status, round_trip_ms, epoch_seconds, epoch_millis, time_known,
		output ready);
endinterface

// ----- hw/rtl/ntp_reply_clock_offset.sv -----
// Top level of the NTP reply clock offset block.
//
//  Channel   Dir  Handshake           Payload
//  events    in   valid / ready       action, now_ms, ntp_seconds, ntp_fraction
//  results   out  valid / ready       status, round_trip_ms, epoch_seconds,
//                                     epoch_millis, time_known
//  limit     in   limit_we (no ready) limit_wdata: round trip limit in ms
//
// Three register stages: input, arithmetic, result. An accepted event passes
// from the input register through the arithmetic register to the result
// register; one event is accepted every cycle while results are taken. The two
// multipliers (divide by 1000 and fraction to ms) sit after the input register;
// the epoch arithmetic sits after them. Each stage moves when the stage behind
// it is empty or moving, so a stalled result holds the pipe and empty stages
// fill up. Reset clears the pipe and all state; the limit returns to 100 ms.
module ntp_reply_clock_offset (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           limit_we,
	input  logic [nrco_pkg::LIMIT_W-1:0]   limit_wdata,
	nrco_event_if.sink                     events,
	nrco_result_if.source                  results
);
	import nrco_pkg::*;

	// Configuration and block state
	logic [LIMIT_W-1:0] limit_q;
	logic               pending_q;
	logic [TIME_W-1:0]  req_time_q;
	logic [TIME_W-1:0]  base_sec_q;
	logic [MS_W-1:0]    base_ms_q;
	logic               base_valid_q;

	// Stage 1: registered event
	logic               v_s1;
	action_t            action_s1;
	logic [TIME_W-1:0]  now_s1;
	logic [TIME_W-1:0]  nsec_s1;
	logic [TIME_W-1:0]  nfrac_s1;

	// Stage 2: decision and products
	logic               v_s2;
	status_t            status_s2;
	logic [TIME_W-1:0]  rtt_s2;
	conv_in_t           conv_s2;

	// Stage 3: result register
	logic               v_s3;
	status_t            status_s3;
	logic [TIME_W-1:0]  rtt_s3;
	logic [TIME_W-1:0]  sec_s3;
	logic [MS_W-1:0]    ms_s3;
	logic               known_s3;

	logic               adv1;
	logic               adv2;
	logic               adv3;
	logic [TIME_W-1:0]  rtt_c;
	status_t            status_c;
	logic [2*TIME_W-1:0] quot_prod;
	logic [FPROD_W-1:0] frac_prod;
	logic [MS_W-1:0]    frac_ms_c;
	conv_out_t          base_c;
	logic               update_c;

	// Pipeline flow: a stage moves when the one behind it is free.
	assign adv3         = !v_s3 || results.ready;
	assign adv2         = !v_s2 || adv3;
	assign adv1         = !v_s1 || adv2;
	assign events.ready = adv1;

	// Limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (limit_we) begin
			limit_q <= limit_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= events.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && events.valid) begin
			action_s1 <= events.action;
			now_s1    <= events.now_ms;
			nsec_s1   <= events.ntp_seconds;
			nfrac_s1  <= events.ntp_fraction;
		end
	end

	// Stage 1 decision against the outstanding request
	assign rtt_c = now_s1 - req_time_q;

	always_comb begin
		priority if (action_s1 == ACT_REQUEST) begin
			status_c = ST_REQUEST_RECORDED;
		end else if (!pending_q) begin
			status_c = ST_REPLY_IGNORED;
		end else if (rtt_c >= TIME_W'(limit_q)) begin
			status_c = ST_REPLY_TOO_SLOW;
		end else begin
			status_c = ST_TIME_UPDATED;
		end
	end

	// Divide by 1000 through the reciprocal, and scale the fraction to ms
	assign quot_prod = (2*TIME_W)'(now_s1) * (2*TIME_W)'(DIV1000_MAGIC);
	assign frac_prod = FPROD_W'(nfrac_s1) * FPROD_W'(MS_PER_S);
	assign frac_ms_c = (frac_prod[FPROD_W-1 -: MS_W] > MS_MAX) ? MS_MAX
		: frac_prod[FPROD_W-1 -: MS_W];

	// Request state moves with the event leaving stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= 1'b0;
			req_time_q <= '0;
		end else if (v_s1 && adv2) begin
			if (action_s1 == ACT_REQUEST) begin
				pending_q  <= 1'b1;
				req_time_q <= now_s1;
			end else begin
				pending_q  <= 1'b0;
			end
		end
	end

	// Stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			status_s2        <= status_c;
			rtt_s2           <= (action_s1 == ACT_REPLY && pending_q) ? rtt_c : '0;
			conv_s2.unix_sec <= nsec_s1 - NTP_UNIX_OFFSET;
			conv_s2.quot     <= quot_prod[DIV1000_SHIFT +: QUOT_W];
			conv_s2.now_lo   <= now_s1[MS_W-1:0];
			conv_s2.frac_ms  <= frac_ms_c;
		end
	end

	// Epoch base arithmetic
	nrco_base_calc u_base_calc (
		.conv (conv_s2),
		.base (base_c)
	);

	assign update_c = v_s2 && adv3 && (status_s2 == ST_TIME_UPDATED);

	// Stored epoch base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_sec_q   <= '0;
			base_ms_q    <= '0;
			base_valid_q <= 1'b0;
		end else if (update_c) begin
			base_sec_q   <= base_c.seconds;
			base_ms_q    <= base_c.millis;
			base_valid_q <= 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			status_s3 <= status_s2;
			rtt_s3    <= rtt_s2;
			sec_s3    <= update_c ? base_c.seconds : base_sec_q;
			ms_s3     <= update_c ? base_c.millis : base_ms_q;
			known_s3  <= update_c || base_valid_q;
		end
	end

	assign results.valid         = v_s3;
	assign results.status        = status_s3;
	assign results.round_trip_ms = rtt_s3;
	assign results.epoch_seconds = sec_s3;
	assign results.epoch_millis  = ms_s3;
	assign results.time_known    = known_s3;

endmodule

// ----- hw/rtl/nrco_base_calc.sv -----
// Epoch base calculation: Unix seconds and milliseconds at local time zero.
module nrco_base_calc (
	input  nrco_pkg::conv_in_t  conv,
	output nrco_pkg::conv_out_t base
);
	import nrco_pkg::*;

	logic [MS_W-1:0] quot_ms_lo;
	logic [MS_W-1:0] rem_ms;
	logic            borrow;
	logic [MS_W-1:0] millis_adj;

	// Remainder of now_ms by 1000. The true value is below 1024, so only the
	// low ten bits of now_ms and of quot*1000 are needed.
	assign quot_ms_lo = MS_W'(conv.quot[MS_W-1:0] * MS_PER_S);
	assign rem_ms     = conv.now_lo - quot_ms_lo;

	// Borrow one second when the reply milliseconds fall below the local ones.
	assign borrow     = conv.frac_ms < rem_ms;
	assign millis_adj = borrow ? MS_PER_S : '0;

	// The result lies in 0..999, so a ten-bit wrapping sum is exact.
	assign base.millis  = conv.frac_ms - rem_ms + millis_adj;
	assign base.seconds = conv.unix_sec - TIME_W'(conv.quot) - TIME_W'(borrow);

endmodule
